// ===== rtl/flht_pkg.sv =====
// Shared widths, operation codes and store write bundle for the handle table.
package flht_pkg;

  localparam int unsigned KindW   = 2;
  localparam int unsigned HandleW = 10;
  localparam int unsigned WordW   = 32;
  localparam int unsigned MaxSlots = 1024;

  typedef enum logic [KindW-1:0] {
    KIND_ADD = 2'd0,
    KIND_DEL = 2'd1,
    KIND_GET = 2'd2
  } kind_e;

  // One write to the slot store; each memory has its own write enable.
  typedef struct packed {
    logic               value_we;
    logic               link_we;
    logic [HandleW-1:0] addr;
    logic [WordW-1:0]   value;
    logic [HandleW-1:0] link;
  } store_wr_t;

endpackage

// ===== rtl/flht_if.sv =====
// Request and response channel interfaces of the handle table.
interface flht_req_if import flht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KindW-1:0]   kind;
  logic [HandleW-1:0] slot_index;
  logic [WordW-1:0]   value;

  modport source (output valid, kind, slot_index, value, input ready);
  modport sink (input valid, kind, slot_index, value, output ready);
endinterface

interface flht_rsp_if import flht_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [HandleW-1:0] handle;
  logic [WordW-1:0]   data;

  modport source (output valid, handle, data, input ready);
  modport sink (input valid, handle, data, output ready);
endinterface

// ===== rtl/free_list_handle_table.sv =====
// Handle table top level: sequencer, free-list head, issue counter and response register.
// After reset the block first clears the slot store, one slot per cycle, over
// min(CAPACITY, 1024) slots, during which req_i.ready stays low. After that, for each beat
// the accept cycle reads the addressed slot's word and link from the synchronous store,
// and the execute state then writes the slot back, updates the free-list head and loads
// the response register. The response register lets the next request be taken while a
// response is still waiting; a request only stalls in the execute state when the
// previous response has not been taken yet. Slot 0 is never handed out, and an add fails
// with handle 0 once the free list is empty and the next fresh slot reaches min(CAPACITY, 1024).
module free_list_handle_table import flht_pkg::*; #(
  parameter int unsigned CAPACITY = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  flht_req_if.sink     req_i,
  flht_rsp_if.source   rsp_o
);

  localparam int unsigned Depth = (CAPACITY < MaxSlots) ? CAPACITY : MaxSlots;
  localparam int unsigned IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e             state_q, state_d;
  logic [IdxW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [HandleW-1:0] free_head_q, free_head_d;
  logic [WordW-1:0]   issued_q, issued_d;

  logic [KindW-1:0]   op_kind_q, op_kind_d;
  logic [HandleW-1:0] op_slot_q, op_slot_d;
  logic [WordW-1:0]   op_val_q, op_val_d;
  logic               op_ok_q, op_ok_d;
  logic               op_fresh_q, op_fresh_d;

  logic               rsp_valid_q, rsp_valid_d;
  logic [HandleW-1:0] rsp_handle_q, rsp_handle_d;
  logic [WordW-1:0]   rsp_data_q, rsp_data_d;

  logic               accept;
  logic               finish;
  logic               handle_ok;
  store_wr_t          wr;
  logic [WordW-1:0]   rd_value;
  logic [HandleW-1:0] rd_link;

  assign req_i.ready  = (state_q == ST_IDLE);
  assign accept       = req_i.valid && req_i.ready;
  assign finish       = (state_q == ST_EXEC) && (!rsp_valid_q || rsp_o.ready);

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.handle = rsp_handle_q;
  assign rsp_o.data   = rsp_data_q;

  assign handle_ok = (req_i.slot_index != '0) &&
                     (WordW'(req_i.slot_index) <= issued_q) &&
                     ({1'b0, req_i.slot_index} < (HandleW+1)'(Depth));

  // Decode the request in the accept cycle so the store read can start at once.
  always_comb begin
    op_kind_d  = op_kind_q;
    op_slot_d  = op_slot_q;
    op_val_d   = op_val_q;
    op_ok_d    = op_ok_q;
    op_fresh_d = op_fresh_q;
    if (accept) begin
      op_kind_d  = req_i.kind;
      op_val_d   = req_i.value;
      op_slot_d  = req_i.slot_index;
      op_ok_d    = 1'b0;
      op_fresh_d = 1'b0;
      case (req_i.kind)
        KIND_ADD: begin
          if (free_head_q != '0) begin
            op_slot_d = free_head_q;
            op_ok_d   = 1'b1;
          end else begin
            op_slot_d  = issued_q[HandleW-1:0] + HandleW'(1);
            op_ok_d    = issued_q < WordW'(Depth - 1);
            op_fresh_d = 1'b1;
          end
        end
        KIND_DEL, KIND_GET: begin
          op_ok_d = handle_ok;
        end
        default: begin
          op_ok_d = 1'b0;
        end
      endcase
    end
  end

  // Execute state: write back the slot and update the list head and counter; the clear state sweeps the store.
  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    free_head_d  = free_head_q;
    issued_d     = issued_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_handle_d = rsp_handle_q;
    rsp_data_d   = rsp_data_q;
    wr           = '0;
    wr.addr      = op_slot_q;

    case (state_q)
      ST_CLEAR: begin
        wr.value_we = 1'b1;
        wr.link_we  = 1'b1;
        wr.addr     = HandleW'(clr_cnt_q);
        clr_cnt_d   = clr_cnt_q + IdxW'(1);
        if (clr_cnt_q == IdxW'(Depth - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (finish) begin
          state_d      = ST_IDLE;
          rsp_valid_d  = 1'b1;
          rsp_handle_d = '0;
          rsp_data_d   = '0;
          case (op_kind_q)
            KIND_ADD: begin
              if (op_ok_q) begin
                rsp_handle_d = op_slot_q;
                wr.value_we  = 1'b1;
                wr.value     = op_val_q;
                if (op_fresh_q) begin
                  wr.link_we  = 1'b1;
                  wr.link     = '0;
                  free_head_d = '0;
                end else begin
                  free_head_d = rd_link;
                end
                if (issued_q != '1) begin
                  issued_d = issued_q + WordW'(1);
                end
              end
            end
            KIND_DEL: begin
              if (op_ok_q) begin
                rsp_data_d  = rd_value;
                wr.value_we = 1'b1;
                wr.value    = '0;
                wr.link_we  = 1'b1;
                wr.link     = free_head_q;
                free_head_d = op_slot_q;
              end
            end
            KIND_GET: begin
              if (op_ok_q) begin
                rsp_data_d = rd_value;
              end
            end
            default: begin
              rsp_data_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_cnt_q    <= '0;
      free_head_q  <= '0;
      issued_q     <= '0;
      op_kind_q    <= '0;
      op_slot_q    <= '0;
      op_val_q     <= '0;
      op_ok_q      <= 1'b0;
      op_fresh_q   <= 1'b0;
      rsp_valid_q  <= 1'b0;
      rsp_handle_q <= '0;
      rsp_data_q   <= '0;
    end else begin
      state_q      <= state_d;
      clr_cnt_q    <= clr_cnt_d;
      free_head_q  <= free_head_d;
      issued_q     <= issued_d;
      op_kind_q    <= op_kind_d;
      op_slot_q    <= op_slot_d;
      op_val_q     <= op_val_d;
      op_ok_q      <= op_ok_d;
      op_fresh_q   <= op_fresh_d;
      rsp_valid_q  <= rsp_valid_d;
      rsp_handle_q <= rsp_handle_d;
      rsp_data_q   <= rsp_data_d;
    end
  end

  flht_store #(
    .Depth (Depth)
  ) u_store (
    .clk_i      (clk_i),
    .rd_en_i    (accept),
    .rd_addr_i  (op_slot_d),
    .wr_i       (wr),
    .rd_value_o (rd_value),
    .rd_link_o  (rd_link)
  );

endmodule

// ===== rtl/flht_store.sv =====
// Slot store: data word memory and link memory, one read and one write port each.
module flht_store import flht_pkg::*; #(
  parameter int unsigned Depth = 1024
) (
  input  logic               clk_i,
  input  logic               rd_en_i,
  input  logic [HandleW-1:0] rd_addr_i,
  input  store_wr_t          wr_i,
  output logic [WordW-1:0]   rd_value_o,
  output logic [HandleW-1:0] rd_link_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [WordW-1:0]   value_mem [Depth];
  logic [HandleW-1:0] link_mem  [Depth];
  logic [IdxW-1:0]    rd_idx;
  logic [IdxW-1:0]    wr_idx;

  assign rd_idx = rd_addr_i[IdxW-1:0];
  assign wr_idx = wr_i.addr[IdxW-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_i.value_we) begin
      value_mem[wr_idx] <= wr_i.value;
    end
    if (wr_i.link_we) begin
      link_mem[wr_idx] <= wr_i.link;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_value_o <= value_mem[rd_idx];
      rd_link_o  <= link_mem[rd_idx];
    end
  end

endmodule
